// ===== rtl/jbsp_pkg.sv =====
// Shared types, character codes and literal tables for the JSON byte structure parser.
// No dependencies; the top level and the testbench import this package.
package jbsp_pkg;

    typedef enum logic [8:0] {
        PM_START     = 9'b000000001,
        PM_OBJ_START = 9'b000000010,
        PM_OBJ_KEY   = 9'b000000100,
        PM_OBJ_COLON = 9'b000001000,
        PM_OBJ_VAL   = 9'b000010000,
        PM_OBJ_NEXT  = 9'b000100000,
        PM_ARR_START = 9'b001000000,
        PM_ARR_VAL   = 9'b010000000,
        PM_ARR_NEXT  = 9'b100000000
    } parse_mode_t;

    typedef enum logic [4:0] {
        LX_IDLE = 5'b00001,
        LX_KEY  = 5'b00010,
        LX_STR  = 5'b00100,
        LX_NUM  = 5'b01000,
        LX_LIT  = 5'b10000
    } lex_mode_t;

    localparam logic [3:0] EV_SKIP      = 4'd0;
    localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
    localparam logic [3:0] EV_ARR_OPEN  = 4'd2;
    localparam logic [3:0] EV_CLOSE     = 4'd3;
    localparam logic [3:0] EV_KEY_OPEN  = 4'd4;
    localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
    localparam logic [3:0] EV_KEY_END   = 4'd6;
    localparam logic [3:0] EV_STR_OPEN  = 4'd7;
    localparam logic [3:0] EV_STR_BYTE  = 4'd8;
    localparam logic [3:0] EV_STR_END   = 4'd9;
    localparam logic [3:0] EV_NUM_BYTE  = 4'd10;
    localparam logic [3:0] EV_LIT_BYTE  = 4'd11;
    localparam logic [3:0] EV_COLON     = 4'd12;
    localparam logic [3:0] EV_COMMA     = 4'd13;

    localparam logic [1:0] ST_RUN        = 2'd0;
    localparam logic [1:0] ST_ROOT       = 2'd1;
    localparam logic [1:0] ST_ERR        = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    localparam logic [1:0] LK_TRUE  = 2'd0;
    localparam logic [1:0] LK_FALSE = 2'd1;
    localparam logic [1:0] LK_NULL  = 2'd2;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;

    typedef struct packed {
        logic [1:0] status;
        logic       closes_number;
        logic [7:0] depth;
        logic [7:0] echo_byte;
        logic [3:0] event_res;
    } result_t;

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] c;
        c = CH_NUL;
        case (kind)
            LK_TRUE: begin
                case (idx)
                    3'd0: c = 8'h74;
                    3'd1: c = 8'h72;
                    3'd2: c = 8'h75;
                    3'd3: c = 8'h65;
                    default: c = CH_NUL;
                endcase
            end
            LK_FALSE: begin
                case (idx)
                    3'd0: c = 8'h66;
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = CH_NUL;
                endcase
            end
            LK_NULL: begin
                case (idx)
                    3'd0: c = 8'h6E;
                    3'd1: c = 8'h75;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h6C;
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] n;
        case (kind)
            LK_TRUE:  n = 3'd4;
            LK_FALSE: n = 3'd5;
            LK_NULL:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_number_byte(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_LOWER_E
            || b == CH_UPPER_E || b == CH_PLUS || b == CH_MINUS;
    endfunction

endpackage

// ===== rtl/jbsp_stack.sv =====
// One-bit-per-level container stack: marks each open level as object or array.
// Single write port, one registered read port; no dependencies.
module jbsp_stack #(
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic                     wr_bit,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                     rd_bit
);

    logic mem [DEPTH];
    logic rd_bit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge aclk) begin
        rd_bit_reg <= mem[rd_addr];
    end

    assign rd_bit = rd_bit_reg;

endmodule

// ===== rtl/json_byte_structure_parser.sv =====
// Top level of the JSON byte structure parser: per-byte tokenizer, depth limit and output skid.
// Depends on jbsp_pkg and jbsp_stack.
//
//  channel | direction | handshake               | payload
//  s_      | in        | s_tvalid / s_tready     | s_tdata = text_byte, s_tlast = end_of_text
//  m_      | out       | m_tvalid / m_tready     | m_tuser = event_res, m_tdata = echo/depth/...
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_data = max_depth
//
// Each byte is classified in the cycle it is accepted; its result is then registered for m_.
// One beat per cycle sustained while m_ is not stalled; the parse state update is the only loop.
// The parent container type for a close is held in the stack's registered read port, which is
// re-addressed every cycle from the next stack pointer. A two-entry output buffer keeps s_tready
// high while one result waits. Reset is synchronous; the stack needs no clearing pass.
module json_byte_structure_parser
    import jbsp_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] echo_byte, [15:8] depth, [16] closes_number,
                                   // [18:17] status, [23:19] zero
    output logic [3:0]  m_tuser,   // [3:0] event_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = (SPW > 8) ? SPW : 8;

    parse_mode_t     pm_reg, pm_next;
    lex_mode_t       lx_reg, lx_next;
    logic [1:0]      lk_reg, lk_next;
    logic [2:0]      li_reg, li_next;
    logic [7:0]      prev_reg, prev_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [1:0]      fs_reg, fs_next;
    logic [7:0]      max_depth_reg;

    result_t         res;
    result_t         m_data_reg;
    result_t         skid_data_reg;
    logic            m_valid_reg;
    logic            skid_valid_reg;

    logic            s_accept;
    logic            ends;
    logic            do_start;
    logic            push;
    logic            push_obj;
    logic            parent_obj;
    logic [CW-1:0]   lim;
    logic [SPW-1:0]  sp_follow;
    logic [SPW-1:0]  rd_ptr;
    logic [7:0]      b;
    logic [3:0]      ev;
    logic            closes;
    logic            value_mode;
    parse_mode_t     after_value;

    assign b         = s_tdata[7:0];
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign ends      = s_tlast || (b == CH_NUL);
    assign cfg_ready = 1'b1;

    assign lim = (CW'(max_depth_reg) > CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH)
                                                         : CW'(max_depth_reg);
    assign value_mode  = (pm_reg == PM_OBJ_VAL) || (pm_reg == PM_ARR_START)
                      || (pm_reg == PM_ARR_VAL);
    assign after_value = (pm_reg == PM_OBJ_VAL) ? PM_OBJ_NEXT : PM_ARR_NEXT;

    always_comb begin
        pm_next   = pm_reg;
        lx_next   = lx_reg;
        lk_next   = lk_reg;
        li_next   = li_reg;
        prev_next = prev_reg;
        sp_next   = sp_reg;
        fs_next   = fs_reg;
        ev        = EV_SKIP;
        closes    = 1'b0;
        do_start  = 1'b0;
        push      = 1'b0;
        push_obj  = 1'b0;

        if (fs_reg == ST_RUN) begin
            if (b == CH_NUL) begin
                if (lx_reg == LX_NUM) begin
                    closes  = 1'b1;
                    lx_next = LX_IDLE;
                end
            end else if (lx_reg == LX_KEY || lx_reg == LX_STR) begin
                if (b == CH_QUOTE && prev_reg != CH_BACKSLASH) begin
                    ev      = (lx_reg == LX_KEY) ? EV_KEY_END : EV_STR_END;
                    lx_next = LX_IDLE;
                end else begin
                    ev = (lx_reg == LX_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
                end
            end else if (lx_reg == LX_NUM) begin
                if (is_number_byte(b)) begin
                    ev = EV_NUM_BYTE;
                end else begin
                    closes   = 1'b1;
                    lx_next  = LX_IDLE;
                    do_start = 1'b1;
                end
            end else if (lx_reg == LX_LIT) begin
                if (li_reg < lit_len(lk_reg) && lit_char(lk_reg, li_reg) == b) begin
                    ev      = EV_LIT_BYTE;
                    li_next = li_reg + 3'd1;
                    if (li_next == lit_len(lk_reg)) begin
                        lx_next = LX_IDLE;
                    end
                end else begin
                    fs_next = ST_ERR;
                end
            end else begin
                do_start = 1'b1;
            end

            if (do_start) begin
                case (b) inside
                    [8'h01:CH_SPACE]: begin
                        ev = EV_SKIP;
                    end
                    CH_LBRACE, CH_LBRACKET: begin
                        if (!(pm_reg == PM_START || value_mode)) begin
                            fs_next = ST_ERR;
                        end else if (CW'(sp_reg) >= lim) begin
                            fs_next = ST_ERR;
                        end else begin
                            push     = 1'b1;
                            push_obj = (b == CH_LBRACE);
                            sp_next  = sp_reg + SPW'(1);
                            pm_next  = (b == CH_LBRACE) ? PM_OBJ_START : PM_ARR_START;
                            ev       = (b == CH_LBRACE) ? EV_OBJ_OPEN : EV_ARR_OPEN;
                        end
                    end
                    CH_RBRACE, CH_RBRACKET: begin
                        if (b == CH_RBRACE && !(pm_reg == PM_OBJ_START
                                                || pm_reg == PM_OBJ_NEXT)) begin
                            fs_next = ST_ERR;
                        end else if (b == CH_RBRACKET && !(pm_reg == PM_ARR_START
                                                           || pm_reg == PM_ARR_NEXT)) begin
                            fs_next = ST_ERR;
                        end else if (sp_reg == '0) begin
                            fs_next = ST_ERR;
                        end else begin
                            sp_next = sp_reg - SPW'(1);
                            ev      = EV_CLOSE;
                            if (sp_next == '0) begin
                                pm_next = PM_START;
                                fs_next = ST_ROOT;
                            end else begin
                                pm_next = parent_obj ? PM_OBJ_NEXT : PM_ARR_NEXT;
                            end
                        end
                    end
                    CH_QUOTE: begin
                        if (pm_reg == PM_OBJ_START || pm_reg == PM_OBJ_KEY) begin
                            lx_next = LX_KEY;
                            pm_next = PM_OBJ_COLON;
                            ev      = EV_KEY_OPEN;
                        end else if (value_mode) begin
                            lx_next = LX_STR;
                            pm_next = after_value;
                            ev      = EV_STR_OPEN;
                        end else begin
                            fs_next = ST_ERR;
                        end
                    end
                    CH_COLON: begin
                        if (pm_reg == PM_OBJ_COLON) begin
                            pm_next = PM_OBJ_VAL;
                            ev      = EV_COLON;
                        end else begin
                            fs_next = ST_ERR;
                        end
                    end
                    CH_COMMA: begin
                        if (pm_reg == PM_OBJ_NEXT) begin
                            pm_next = PM_OBJ_KEY;
                            ev      = EV_COMMA;
                        end else if (pm_reg == PM_ARR_NEXT) begin
                            pm_next = PM_ARR_VAL;
                            ev      = EV_COMMA;
                        end else begin
                            fs_next = ST_ERR;
                        end
                    end
                    CH_LOWER_T, CH_LOWER_F, CH_LOWER_N: begin
                        if (value_mode) begin
                            lk_next = (b == CH_LOWER_T) ? LK_TRUE
                                    : (b == CH_LOWER_F) ? LK_FALSE : LK_NULL;
                            li_next = 3'd1;
                            lx_next = LX_LIT;
                            pm_next = after_value;
                            ev      = EV_LIT_BYTE;
                        end else begin
                            fs_next = ST_ERR;
                        end
                    end
                    CH_MINUS, [CH_ZERO:CH_NINE]: begin
                        if (value_mode) begin
                            lx_next = LX_NUM;
                            pm_next = after_value;
                            ev      = EV_NUM_BYTE;
                        end else begin
                            fs_next = ST_ERR;
                        end
                    end
                    default: begin
                        fs_next = ST_ERR;
                    end
                endcase
                if (fs_next == ST_ERR) begin
                    ev = EV_SKIP;
                end
            end

            prev_next = b;
            if (ends && fs_next == ST_RUN) begin
                fs_next = (lx_next == LX_KEY || lx_next == LX_STR) ? ST_ERR : ST_INCOMPLETE;
            end
        end

        res.event_res     = ev;
        res.echo_byte     = b;
        res.depth         = 8'(sp_next);
        res.closes_number = closes;
        res.status        = fs_next;
    end

    // The read port always tracks the entry below the top for the pointer of the next cycle.
    assign sp_follow = s_accept ? (ends ? '0 : sp_next) : sp_reg;
    assign rd_ptr    = sp_follow - SPW'(2);

    jbsp_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (s_accept && push),
        .wr_addr (sp_reg[AW-1:0]),
        .wr_bit  (push_obj),
        .rd_addr (rd_ptr[AW-1:0]),
        .rd_bit  (parent_obj)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_reg        <= PM_START;
            lx_reg        <= LX_IDLE;
            lk_reg        <= LK_TRUE;
            li_reg        <= 3'd0;
            prev_reg      <= CH_NUL;
            sp_reg        <= '0;
            fs_reg        <= ST_RUN;
            max_depth_reg <= 8'd128;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_depth_reg <= cfg_data;
            end
            if (s_accept) begin
                if (ends) begin
                    pm_reg   <= PM_START;
                    lx_reg   <= LX_IDLE;
                    lk_reg   <= LK_TRUE;
                    li_reg   <= 3'd0;
                    prev_reg <= CH_NUL;
                    sp_reg   <= '0;
                    fs_reg   <= ST_RUN;
                end else begin
                    pm_reg   <= pm_next;
                    lx_reg   <= lx_next;
                    lk_reg   <= lk_next;
                    li_reg   <= li_next;
                    prev_reg <= prev_next;
                    sp_reg   <= sp_next;
                    fs_reg   <= fs_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                m_data_reg <= res;
            end
        end else if (s_accept) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.event_res;
    assign m_tdata  = {5'd0, m_data_reg.status, m_data_reg.closes_number,
                       m_data_reg.depth, m_data_reg.echo_byte};

    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held while output register is empty");

    a_depth_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(sp_reg) <= CW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && ends) |=> (sp_reg == '0 && fs_reg == ST_RUN && lx_reg == LX_IDLE))
        else $error("parser not cleared after end of text");

    a_no_push_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (fs_reg != ST_RUN && s_accept) |=> $stable(sp_reg) || sp_reg == '0)
        else $error("stack moved after parse finished");

endmodule

// ===== test/json_byte_structure_parser_tb.sv =====
// Self-checking testbench for json_byte_structure_parser: directed and random JSON text with
// a token-level predictor, random stalls on both streams and several depth-limit settings.
// Depends on jbsp_pkg and the RTL top level.
module json_byte_structure_parser_tb;
    import jbsp_pkg::*;

    localparam int unsigned STACK_LEVELS = 128;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } text_beat_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    json_byte_structure_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predictor state.
    parse_mode_t pmode;
    lex_mode_t   lmode;
    logic [1:0]  lkind;
    logic [2:0]  lidx;
    logic [7:0]  prev_byte;
    bit          nest_is_obj [0:STACK_LEVELS-1];
    logic [7:0]  sp;
    logic [1:0]  fstat;
    logic [7:0]  depth_limit;

    text_beat_t  text_q[$];
    result_t     event_q[$];
    logic [7:0]  draft[$];

    int unsigned s_gap, m_stall, s_gap_max, m_gap_max;
    int unsigned mismatches, beats_in, settings_used, cycle_count;
    int unsigned doc_ends [0:3];
    result_t     fresh, want;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_parser();
        pmode = PM_START;
        lmode = LX_IDLE;
        lkind = LK_TRUE;
        lidx = 3'd0;
        prev_byte = CH_NUL;
        sp = 8'd0;
        fstat = ST_RUN;
    endfunction

    function automatic logic [3:0] mark_error();
        fstat = ST_ERR;
        return EV_SKIP;
    endfunction

    function automatic bit value_slot();
        return pmode == PM_OBJ_VAL || pmode == PM_ARR_START || pmode == PM_ARR_VAL;
    endfunction

    function automatic parse_mode_t next_after_value();
        return (pmode == PM_OBJ_START || pmode == PM_OBJ_VAL) ? PM_OBJ_NEXT : PM_ARR_NEXT;
    endfunction

    function automatic logic [3:0] open_token(input logic [7:0] b);
        int unsigned lim;
        if (b >= 8'd1 && b <= CH_SPACE)
            return EV_SKIP;
        case (b)
            CH_LBRACE, CH_LBRACKET: begin
                if (!(pmode == PM_START || value_slot()))
                    return mark_error();
                lim = (depth_limit > STACK_LEVELS) ? STACK_LEVELS : depth_limit;
                if (sp >= lim)
                    return mark_error();
                nest_is_obj[sp] = (b == CH_LBRACE);
                sp = sp + 8'd1;
                pmode = (b == CH_LBRACE) ? PM_OBJ_START : PM_ARR_START;
                return (b == CH_LBRACE) ? EV_OBJ_OPEN : EV_ARR_OPEN;
            end
            CH_RBRACE, CH_RBRACKET: begin
                if (b == CH_RBRACE && !(pmode == PM_OBJ_START || pmode == PM_OBJ_NEXT))
                    return mark_error();
                if (b == CH_RBRACKET && !(pmode == PM_ARR_START || pmode == PM_ARR_NEXT))
                    return mark_error();
                if (sp == 8'd0)
                    return mark_error();
                sp = sp - 8'd1;
                if (sp == 8'd0) begin
                    pmode = PM_START;
                    fstat = ST_ROOT;
                end else begin
                    pmode = nest_is_obj[sp - 8'd1] ? PM_OBJ_NEXT : PM_ARR_NEXT;
                end
                return EV_CLOSE;
            end
            CH_QUOTE: begin
                if (pmode == PM_OBJ_START || pmode == PM_OBJ_KEY) begin
                    lmode = LX_KEY;
                    pmode = PM_OBJ_COLON;
                    return EV_KEY_OPEN;
                end
                if (!value_slot())
                    return mark_error();
                lmode = LX_STR;
                pmode = next_after_value();
                return EV_STR_OPEN;
            end
            CH_COLON: begin
                if (pmode != PM_OBJ_COLON)
                    return mark_error();
                pmode = PM_OBJ_VAL;
                return EV_COLON;
            end
            CH_COMMA: begin
                if (pmode == PM_OBJ_NEXT)
                    pmode = PM_OBJ_KEY;
                else if (pmode == PM_ARR_NEXT)
                    pmode = PM_ARR_VAL;
                else
                    return mark_error();
                return EV_COMMA;
            end
            CH_LOWER_T, CH_LOWER_F, CH_LOWER_N: begin
                if (!value_slot())
                    return mark_error();
                lkind = (b == CH_LOWER_T) ? LK_TRUE : (b == CH_LOWER_F) ? LK_FALSE : LK_NULL;
                lidx = 3'd1;
                lmode = LX_LIT;
                pmode = next_after_value();
                return EV_LIT_BYTE;
            end
            default: begin
                if (b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE)) begin
                    if (!value_slot())
                        return mark_error();
                    lmode = LX_NUM;
                    pmode = next_after_value();
                    return EV_NUM_BYTE;
                end
                return mark_error();
            end
        endcase
    endfunction

    function automatic result_t tokenize_byte(input logic [7:0] b, input logic eot);
        result_t     r;
        logic        ends;
        logic [3:0]  ev;
        logic        closes;
        logic [39:0] word;
        logic [2:0]  word_len;
        ends = eot || b == CH_NUL;
        ev = EV_SKIP;
        closes = 1'b0;
        if (fstat == ST_RUN) begin
            if (b == CH_NUL) begin
                if (lmode == LX_NUM) begin
                    closes = 1'b1;
                    lmode = LX_IDLE;
                end
            end else if (lmode == LX_KEY || lmode == LX_STR) begin
                if (b == CH_QUOTE && prev_byte != CH_BACKSLASH) begin
                    ev = (lmode == LX_KEY) ? EV_KEY_END : EV_STR_END;
                    lmode = LX_IDLE;
                end else begin
                    ev = (lmode == LX_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
                end
            end else if (lmode == LX_NUM) begin
                if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_LOWER_E
                        || b == CH_UPPER_E || b == CH_PLUS || b == CH_MINUS) begin
                    ev = EV_NUM_BYTE;
                end else begin
                    closes = 1'b1;
                    lmode = LX_IDLE;
                    ev = open_token(b);
                end
            end else if (lmode == LX_LIT) begin
                word_len = (lkind == LK_FALSE) ? 3'd5 : 3'd4;
                word = (lkind == LK_TRUE) ? "true" : (lkind == LK_FALSE) ? "false" : "null";
                if (lidx < word_len && word[8 * (word_len - 1 - lidx) +: 8] == b) begin
                    ev = EV_LIT_BYTE;
                    lidx = lidx + 3'd1;
                    if (lidx == word_len)
                        lmode = LX_IDLE;
                end else begin
                    ev = mark_error();
                end
            end else begin
                ev = open_token(b);
            end
            prev_byte = b;
            if (ends && fstat == ST_RUN)
                fstat = (lmode == LX_KEY || lmode == LX_STR) ? ST_ERR : ST_INCOMPLETE;
        end
        r.event_res = ev;
        r.echo_byte = b;
        r.depth = sp;
        r.closes_number = closes;
        r.status = fstat;
        if (ends)
            clear_parser();
        return r;
    endfunction

    // Input stream driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                fresh = tokenize_byte(s_tdata, s_tlast);
                event_q.push_back(fresh);
                beats_in++;
                if (s_tlast || s_tdata == CH_NUL)
                    doc_ends[fresh.status]++;
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    s_tdata <= text_q[0].ch;
                    s_tlast <= text_q[0].last;
                    s_tvalid <= 1'b1;
                    text_q.pop_front();
                    s_gap = $urandom_range(0, s_gap_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Result stream monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (event_q.size() == 0) begin
                    $error("Result beat with no byte outstanding: tuser %0d tdata %h",
                           m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = event_q.pop_front();
                    compare_field("event_res", want.event_res, m_tuser);
                    compare_field("echo_byte", want.echo_byte, m_tdata[7:0]);
                    compare_field("depth", want.depth, m_tdata[15:8]);
                    compare_field("closes_number", want.closes_number, m_tdata[16]);
                    compare_field("status", want.status, m_tdata[18:17]);
                end
                m_stall = $urandom_range(0, m_gap_max);
            end else if (m_stall > 0) begin
                m_stall--;
            end
            m_tready <= (m_stall == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout with %0d results outstanding.", event_q.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_beat(input logic [7:0] ch, input logic last);
        text_beat_t t;
        t.ch = ch;
        t.last = last;
        text_q.push_back(t);
    endtask

    task automatic queue_text(input string s, input logic last);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_beat(s[i], last && i == s.len() - 1);
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (text_q.size() != 0 || s_tvalid || event_q.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_depth_limit(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        depth_limit = v;
        settings_used++;
    endtask

    task automatic add_gap();
        int unsigned pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            draft.push_back(CH_SPACE);
        else if (pick == 1)
            draft.push_back(8'($urandom_range(1, 31)));
    endtask

    task automatic add_word(input string w);
        int i;
        for (i = 0; i < w.len(); i++)
            draft.push_back(w[i]);
    endtask

    task automatic add_quoted();
        int unsigned n, i;
        logic [7:0] c;
        draft.push_back(CH_QUOTE);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_QUOTE) begin
                draft.push_back(CH_BACKSLASH);
                draft.push_back(c);
            end else if (c == CH_BACKSLASH) begin
                draft.push_back(c);
                draft.push_back(CH_LOWER_N);
            end else begin
                draft.push_back(c);
            end
        end
        draft.push_back(CH_QUOTE);
    endtask

    task automatic add_number();
        if ($urandom_range(0, 2) == 0)
            draft.push_back(CH_MINUS);
        repeat ($urandom_range(1, 3)) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
            draft.push_back(CH_DOT);
            repeat ($urandom_range(1, 2)) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            draft.push_back($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
            if ($urandom_range(0, 1))
                draft.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic add_value(input int unsigned lvl);
        int unsigned pick, n, i;
        pick = (lvl >= 3) ? $urandom_range(0, 2) : $urandom_range(0, 5);
        add_gap();
        case (pick)
            0: add_number();
            1: add_quoted();
            2: begin
                n = $urandom_range(0, 2);
                add_word(n == 0 ? "true" : n == 1 ? "false" : "null");
            end
            3, 4: begin
                draft.push_back(CH_LBRACE);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) begin
                    if (i > 0)
                        draft.push_back(CH_COMMA);
                    add_gap();
                    add_quoted();
                    add_gap();
                    draft.push_back(CH_COLON);
                    add_value(lvl + 1);
                end
                add_gap();
                draft.push_back(CH_RBRACE);
            end
            default: begin
                draft.push_back(CH_LBRACKET);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) begin
                    if (i > 0)
                        draft.push_back(CH_COMMA);
                    add_value(lvl + 1);
                end
                add_gap();
                draft.push_back(CH_RBRACKET);
            end
        endcase
        add_gap();
    endtask

    // Most documents go out intact; the rest are corrupted, cut short, followed by junk,
    // or ended by a zero byte.
    task automatic ship_draft(output int unsigned shipped);
        int unsigned style, count, k;
        style = $urandom_range(0, 9);
        if (style == 0)
            draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
        if (style == 2)
            repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(1, 255)));
        count = draft.size();
        if (style == 1 && count > 1)
            count = $urandom_range(1, count - 1);
        if (style == 3) begin
            for (k = 0; k < count; k++)
                queue_beat(draft[k], 1'b0);
            queue_beat(CH_NUL, 1'($urandom_range(0, 1)));
            count++;
        end else begin
            for (k = 0; k < count; k++)
                queue_beat(draft[k], k == count - 1);
        end
        shipped = count;
    endtask

    task automatic random_docs(input int unsigned budget);
        int unsigned queued, n;
        queued = 0;
        while (queued < budget) begin
            draft.delete();
            add_value(0);
            ship_draft(n);
            queued += n;
        end
    endtask

    initial begin
        int i;
        clear_parser();
        depth_limit = 8'd128;
        s_gap_max = 6;
        m_gap_max = 6;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        set_depth_limit(8'd128);
        queue_text(" \t{\"a\":[1,-2.5e+3,true,false,null,\"s\\\"x\"]}", 1'b1);
        queue_text("[12", 1'b0);
        queue_beat(CH_NUL, 1'b0);
        queue_text("{\"k", 1'b1);
        queue_text("[a]", 1'b1);
        queue_text("[nu1]", 1'b1);
        queue_text("[[],{}] x", 1'b1);
        queue_text("}", 1'b1);
        queue_text("[}", 1'b1);
        queue_beat(8'hFF, 1'b1);
        queue_beat(8'h80, 1'b1);
        queue_text("{\"a\" 1}", 1'b1);
        queue_text("[1,]", 1'b1);
        queue_text("[1}", 1'b1);
        queue_text("7", 1'b1);
        wait_idle();

        // Nesting up to the full stack, once past it and once right at it before closing five levels.
        for (i = 0; i < STACK_LEVELS; i++)
            queue_beat(CH_LBRACKET, 1'b0);
        queue_beat(CH_LBRACKET, 1'b1);
        for (i = 0; i < STACK_LEVELS - 1; i++)
            queue_beat(CH_LBRACKET, 1'b0);
        queue_text("{\"k\":1}", 1'b0);
        for (i = 0; i < 4; i++)
            queue_beat(CH_RBRACKET, i == 3);
        wait_idle();

        set_depth_limit(8'd1);
        random_docs(30);
        wait_idle();
        set_depth_limit(8'd2);
        random_docs(30);
        wait_idle();
        s_gap_max = 0;
        m_gap_max = 0;
        set_depth_limit(8'd127);
        random_docs(30);
        wait_idle();
        s_gap_max = 6;
        m_gap_max = 6;
        set_depth_limit(8'($urandom_range(3, 126)));
        random_docs(60);
        wait_idle();
        repeat (8) @(posedge aclk);

        $display("Checked %0d text bytes under %0d depth-limit settings.", beats_in,
                 settings_used);
        $display("Documents ended closed %0d, in error %0d, incomplete %0d.",
                 doc_ends[ST_ROOT], doc_ends[ST_ERR], doc_ends[ST_INCOMPLETE]);
        if (mismatches == 0 && event_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
